FILE: src/imhdk_pkg.sv
// shared types and constants for the indexed min-heap with decrease-key
`timescale 1ns / 1ps
`default_nettype none
package imhdk_pkg;

   localparam int CELL_BITS  = 12;
   localparam int SLOT_BITS  = 13;
   localparam int KEY_BITS   = 32;
   localparam int GRID_CELLS = 4096;

   localparam logic [SLOT_BITS-1:0] SLOT_NONE = SLOT_BITS'(GRID_CELLS);

   localparam logic [1:0] CMD_SET = 2'd0;
   localparam logic [1:0] CMD_ADD = 2'd1;
   localparam logic [1:0] CMD_POP = 2'd2;

   typedef logic [CELL_BITS-1:0]        cell_type;
   typedef logic [SLOT_BITS-1:0]        slot_type;
   typedef logic signed [KEY_BITS-1:0]  key_type;

   typedef struct packed {
      logic     ord_we;
      cell_type ord_waddr;
      cell_type ord_wdata;
      cell_type ord_raddr;
      logic     key_we;
      cell_type key_waddr;
      key_type  key_wdata;
      cell_type key_raddr;
      logic     slot_we;
      cell_type slot_waddr;
      slot_type slot_wdata;
      cell_type slot_raddr;
   } mem_cmd_type;

   typedef struct packed {
      cell_type popped_cell;
      key_type  popped_key;
      logic     heap_empty;
      slot_type heap_count;
   } res_type;

endpackage
`default_nettype wire

FILE: src/imhdk_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module imhdk_ram #(
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [2**ADDR_BITS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: src/imhdk_cmp.sv
// shared signed key comparator, strict less-than
`timescale 1ns / 1ps
`default_nettype none
module imhdk_cmp (
   input  wire imhdk_pkg::key_type lhs,
   input  wire imhdk_pkg::key_type rhs,
   output logic                    less
);

   assign less = ($signed(lhs) < $signed(rhs));

endmodule
`default_nettype wire

FILE: src/imhdk_ctrl.sv
// command sequencer: set, add with sift-up, pop with sift-down
`timescale 1ns / 1ps
`default_nettype none
module imhdk_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [1:0]             in_cmd,
   input  wire imhdk_pkg::cell_type    in_cell,
   input  wire imhdk_pkg::key_type     in_key,
   output imhdk_pkg::mem_cmd_type      mem,
   input  wire imhdk_pkg::cell_type    ord_rdata,
   input  wire imhdk_pkg::key_type     key_rdata,
   input  wire imhdk_pkg::slot_type    slot_rdata,
   output logic                        res_valid,
   input  wire logic                   res_ready,
   output imhdk_pkg::res_type          res
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_SET     = 5'd1;
   localparam logic [4:0] ST_A_RD    = 5'd2;
   localparam logic [4:0] ST_A_CHK   = 5'd3;
   localparam logic [4:0] ST_SU_RDP  = 5'd4;
   localparam logic [4:0] ST_SU_HP   = 5'd5;
   localparam logic [4:0] ST_SU_KP   = 5'd6;
   localparam logic [4:0] ST_SU_HU   = 5'd7;
   localparam logic [4:0] ST_SU_CMP  = 5'd8;
   localparam logic [4:0] ST_SU_WR2  = 5'd9;
   localparam logic [4:0] ST_P_START = 5'd10;
   localparam logic [4:0] ST_P_TOP   = 5'd11;
   localparam logic [4:0] ST_P_MOV   = 5'd12;
   localparam logic [4:0] ST_P_KM    = 5'd13;
   localparam logic [4:0] ST_SD_RD   = 5'd14;
   localparam logic [4:0] ST_SD_L    = 5'd15;
   localparam logic [4:0] ST_SD_R    = 5'd16;
   localparam logic [4:0] ST_SD_SEL  = 5'd17;
   localparam logic [4:0] ST_SD_CMP  = 5'd18;
   localparam logic [4:0] ST_SD_WR2  = 5'd19;
   localparam logic [4:0] ST_DONE    = 5'd20;

   logic [4:0]          state_ff, state_in;
   imhdk_pkg::slot_type fill_ff, fill_in;

   logic [1:0]          cmd_ff, cmd_in;
   imhdk_pkg::cell_type cell_ff, cell_in;
   imhdk_pkg::key_type  key_ff, key_in;
   imhdk_pkg::cell_type pos_ff, pos_in;
   imhdk_pkg::cell_type child_ff, child_in;
   imhdk_pkg::cell_type ccell_ff, ccell_in;
   imhdk_pkg::cell_type rcell_ff, rcell_in;
   imhdk_pkg::cell_type mover_ff, mover_in;
   imhdk_pkg::key_type  ckey_ff, ckey_in;
   imhdk_pkg::key_type  mk_ff, mk_in;
   imhdk_pkg::cell_type top_ff, top_in;
   imhdk_pkg::key_type  pkey_ff, pkey_in;
   logic                empty_ff, empty_in;

   imhdk_pkg::key_type  cmp_lhs, cmp_rhs;
   logic                cmp_less;

   imhdk_pkg::cell_type pos_m1, up_idx, up_m1, upup_idx;
   imhdk_pkg::slot_type lc_idx, rc_idx;

   imhdk_cmp u_cmp (
      .lhs  (cmp_lhs),
      .rhs  (cmp_rhs),
      .less (cmp_less)
   );

   // parent and child slots of the current position
   assign pos_m1   = pos_ff - imhdk_pkg::CELL_BITS'(1);
   assign up_idx   = {1'b0, pos_m1[imhdk_pkg::CELL_BITS-1:1]};
   assign up_m1    = up_idx - imhdk_pkg::CELL_BITS'(1);
   assign upup_idx = {1'b0, up_m1[imhdk_pkg::CELL_BITS-1:1]};
   assign lc_idx   = {pos_ff, 1'b1};
   assign rc_idx   = {pos_ff, 1'b0} + imhdk_pkg::SLOT_BITS'(2);

   always_comb begin
      case (state_ff)
         ST_SD_SEL: begin
            cmp_lhs = key_rdata;
            cmp_rhs = ckey_ff;
         end
         ST_SD_CMP: begin
            cmp_lhs = ckey_ff;
            cmp_rhs = mk_ff;
         end
         default: begin
            cmp_lhs = ckey_ff;
            cmp_rhs = key_rdata;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      cmd_in   = cmd_ff;
      cell_in  = cell_ff;
      key_in   = key_ff;
      pos_in   = pos_ff;
      child_in = child_ff;
      ccell_in = ccell_ff;
      rcell_in = rcell_ff;
      mover_in = mover_ff;
      ckey_in  = ckey_ff;
      mk_in    = mk_ff;
      top_in   = top_ff;
      pkey_in  = pkey_ff;
      empty_in = empty_ff;
      mem      = '0;
      mem.slot_raddr = cell_ff;

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd_in   = in_cmd;
               cell_in  = in_cell;
               key_in   = in_key;
               top_in   = '0;
               pkey_in  = '0;
               empty_in = 1'b0;
               case (in_cmd)
                  imhdk_pkg::CMD_SET: state_in = ST_SET;
                  imhdk_pkg::CMD_ADD: state_in = ST_A_RD;
                  imhdk_pkg::CMD_POP: state_in = ST_P_START;
                  default:            state_in = ST_DONE;
               endcase
            end
         end
         ST_SET: begin
            mem.key_we     = 1'b1;
            mem.key_waddr  = cell_ff;
            mem.key_wdata  = key_ff;
            mem.slot_we    = 1'b1;
            mem.slot_waddr = cell_ff;
            mem.slot_wdata = imhdk_pkg::SLOT_NONE;
            state_in       = ST_DONE;
         end
         ST_A_RD: begin
            mem.key_we    = 1'b1;
            mem.key_waddr = cell_ff;
            mem.key_wdata = key_ff;
            state_in      = ST_A_CHK;
         end
         ST_A_CHK: begin
            mk_in = key_ff;
            if (slot_rdata >= imhdk_pkg::SLOT_NONE) begin
               if (fill_ff < imhdk_pkg::SLOT_NONE) begin
                  mem.ord_we     = 1'b1;
                  mem.ord_waddr  = fill_ff[imhdk_pkg::CELL_BITS-1:0];
                  mem.ord_wdata  = cell_ff;
                  mem.slot_we    = 1'b1;
                  mem.slot_waddr = cell_ff;
                  mem.slot_wdata = fill_ff;
                  pos_in         = fill_ff[imhdk_pkg::CELL_BITS-1:0];
                  fill_in        = fill_ff + imhdk_pkg::SLOT_BITS'(1);
                  state_in       = (fill_ff == '0) ? ST_DONE : ST_SU_RDP;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               pos_in   = slot_rdata[imhdk_pkg::CELL_BITS-1:0];
               state_in = (slot_rdata == '0) ? ST_DONE : ST_SU_RDP;
            end
         end
         ST_SU_RDP: begin
            mem.ord_raddr = pos_ff;
            state_in      = ST_SU_HP;
         end
         ST_SU_HP: begin
            mem.key_raddr = ord_rdata;
            state_in      = ST_SU_KP;
         end
         ST_SU_KP: begin
            ckey_in       = key_rdata;
            mem.ord_raddr = up_idx;
            state_in      = ST_SU_HU;
         end
         ST_SU_HU: begin
            ccell_in      = ord_rdata;
            mem.key_raddr = ord_rdata;
            state_in      = ST_SU_CMP;
         end
         ST_SU_CMP: begin
            if (cmp_less) begin
               mem.ord_we     = 1'b1;
               mem.ord_waddr  = pos_ff;
               mem.ord_wdata  = ccell_ff;
               mem.slot_we    = 1'b1;
               mem.slot_waddr = ccell_ff;
               mem.slot_wdata = {1'b0, pos_ff};
               state_in       = ST_SU_WR2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SU_WR2: begin
            mem.ord_we     = 1'b1;
            mem.ord_waddr  = up_idx;
            mem.ord_wdata  = cell_ff;
            mem.slot_we    = 1'b1;
            mem.slot_waddr = cell_ff;
            mem.slot_wdata = {1'b0, up_idx};
            mem.ord_raddr  = upup_idx;
            pos_in         = up_idx;
            ckey_in        = mk_ff;
            state_in       = (up_idx == '0) ? ST_DONE : ST_SU_HU;
         end
         ST_P_START: begin
            if (fill_ff == '0) begin
               empty_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               fill_in       = fill_ff - imhdk_pkg::SLOT_BITS'(1);
               mem.ord_raddr = '0;
               state_in      = ST_P_TOP;
            end
         end
         ST_P_TOP: begin
            top_in        = ord_rdata;
            mem.key_raddr = ord_rdata;
            mem.ord_raddr = fill_ff[imhdk_pkg::CELL_BITS-1:0];
            state_in      = ST_P_MOV;
         end
         ST_P_MOV: begin
            pkey_in        = key_rdata;
            mover_in       = ord_rdata;
            mem.ord_we     = 1'b1;
            mem.ord_waddr  = '0;
            mem.ord_wdata  = ord_rdata;
            mem.slot_we    = 1'b1;
            mem.slot_waddr = ord_rdata;
            mem.slot_wdata = '0;
            mem.key_raddr  = ord_rdata;
            state_in       = ST_P_KM;
         end
         ST_P_KM: begin
            mk_in    = key_rdata;
            pos_in   = '0;
            state_in = ST_SD_RD;
         end
         ST_SD_RD: begin
            if (lc_idx >= fill_ff) begin
               state_in = ST_DONE;
            end else begin
               mem.ord_raddr = lc_idx[imhdk_pkg::CELL_BITS-1:0];
               state_in      = ST_SD_L;
            end
         end
         ST_SD_L: begin
            ccell_in      = ord_rdata;
            mem.key_raddr = ord_rdata;
            mem.ord_raddr = rc_idx[imhdk_pkg::CELL_BITS-1:0];
            state_in      = ST_SD_R;
         end
         ST_SD_R: begin
            ckey_in  = key_rdata;
            child_in = lc_idx[imhdk_pkg::CELL_BITS-1:0];
            rcell_in = ord_rdata;
            if (rc_idx < fill_ff) begin
               mem.key_raddr = ord_rdata;
               state_in      = ST_SD_SEL;
            end else begin
               state_in = ST_SD_CMP;
            end
         end
         ST_SD_SEL: begin
            if (cmp_less) begin
               ckey_in  = key_rdata;
               ccell_in = rcell_ff;
               child_in = rc_idx[imhdk_pkg::CELL_BITS-1:0];
            end
            state_in = ST_SD_CMP;
         end
         ST_SD_CMP: begin
            if (cmp_less) begin
               mem.ord_we     = 1'b1;
               mem.ord_waddr  = pos_ff;
               mem.ord_wdata  = ccell_ff;
               mem.slot_we    = 1'b1;
               mem.slot_waddr = ccell_ff;
               mem.slot_wdata = {1'b0, pos_ff};
               state_in       = ST_SD_WR2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SD_WR2: begin
            mem.ord_we     = 1'b1;
            mem.ord_waddr  = child_ff;
            mem.ord_wdata  = mover_ff;
            mem.slot_we    = 1'b1;
            mem.slot_waddr = mover_ff;
            mem.slot_wdata = {1'b0, child_ff};
            pos_in         = child_ff;
            state_in       = ST_SD_RD;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      cell_ff  <= cell_in;
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      child_ff <= child_in;
      ccell_ff <= ccell_in;
      rcell_ff <= rcell_in;
      mover_ff <= mover_in;
      ckey_ff  <= ckey_in;
      mk_ff    <= mk_in;
      top_ff   <= top_in;
      pkey_ff  <= pkey_in;
      empty_ff <= empty_in;
   end

   assign in_ready        = (state_ff == ST_IDLE);
   assign res_valid       = (state_ff == ST_DONE);
   assign res.popped_cell = (cmd_ff == imhdk_pkg::CMD_POP) ? top_ff : '0;
   assign res.popped_key  = (cmd_ff == imhdk_pkg::CMD_POP) ? pkey_ff : '0;
   assign res.heap_empty  = empty_ff;
   assign res.heap_count  = fill_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= imhdk_pkg::SLOT_NONE)
      else $error("heap fill beyond grid size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> state_ff != ST_IDLE)
      else $error("accepted command left sequencer idle");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_P_START && fill_ff != '0 |=>
         fill_ff == $past(fill_ff) - imhdk_pkg::SLOT_BITS'(1))
      else $error("pop did not shrink heap by one");

   a_sd_child: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SD_CMP && mem.ord_we |->
         {1'b0, child_ff} < fill_ff && child_ff > pos_ff)
      else $error("sift-down child outside heap");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.heap_empty |-> res.heap_count == '0 && res.popped_cell == '0)
      else $error("empty pop with nonzero result");

endmodule
`default_nettype wire

FILE: src/indexed_min_heap_decrease_key.sv
// top level: heap memories, sequencer and registered result stage
//
//  channel | dir | handshake            | payload
//  req_    | in  | req_tvalid/tready    | tuser: cmd; tdata: cell_index, key_value
//  rsp_    | out | rsp_tvalid/tready    | tuser: heap_empty; tdata: cell, key, count
//
// one command at a time: set writes the key and marks the cell absent; add writes the key,
// appends the cell if absent and not full, then sifts up; pop flags empty or moves the
// last cell to the root and sifts down; each level costs dependent reads on one read port
// reset clears the sequencer and the fill count; memories need no clearing
// a stalled result holds in the output register while the next command runs
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_decrease_key (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // cell_index[11:0], key_value[43:12]
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // popped_cell[11:0], popped_key[43:12], heap_count[56:44]
   output logic [0:0]       rsp_tuser    // heap_empty[0]
);

   imhdk_pkg::mem_cmd_type mem;
   imhdk_pkg::cell_type    ord_rdata;
   imhdk_pkg::key_type     key_rdata;
   imhdk_pkg::slot_type    slot_rdata;
   imhdk_pkg::res_type     res;
   logic                   res_valid;
   logic                   res_ready;

   logic                   rsp_valid_ff, rsp_valid_in;
   imhdk_pkg::res_type     rsp_res_ff, rsp_res_in;

   imhdk_ram #(.WIDTH(imhdk_pkg::CELL_BITS), .ADDR_BITS(imhdk_pkg::CELL_BITS)) u_ord (
      .clock (clock),
      .we    (mem.ord_we),
      .waddr (mem.ord_waddr),
      .wdata (mem.ord_wdata),
      .raddr (mem.ord_raddr),
      .rdata (ord_rdata)
   );

   imhdk_ram #(.WIDTH(imhdk_pkg::KEY_BITS), .ADDR_BITS(imhdk_pkg::CELL_BITS)) u_key (
      .clock (clock),
      .we    (mem.key_we),
      .waddr (mem.key_waddr),
      .wdata (mem.key_wdata),
      .raddr (mem.key_raddr),
      .rdata (key_rdata)
   );

   imhdk_ram #(.WIDTH(imhdk_pkg::SLOT_BITS), .ADDR_BITS(imhdk_pkg::CELL_BITS)) u_slot (
      .clock (clock),
      .we    (mem.slot_we),
      .waddr (mem.slot_waddr),
      .wdata (mem.slot_wdata),
      .raddr (mem.slot_raddr),
      .rdata (slot_rdata)
   );

   imhdk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_cell    (req_tdata[11:0]),
      .in_key     (req_tdata[43:12]),
      .mem        (mem),
      .ord_rdata  (ord_rdata),
      .key_rdata  (key_rdata),
      .slot_rdata (slot_rdata),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // output register frees as soon as the held transfer completes
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_res_ff.heap_count, rsp_res_ff.popped_key,
                        rsp_res_ff.popped_cell};
   assign rsp_tuser  = rsp_res_ff.heap_empty;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the indexed min-heap: command streams checked by a scoreboard class
`timescale 1ns / 1ps
package tb_heap_pkg;

   localparam logic [1:0] CMD_RESERVED  = 2'd3;
   localparam logic [1:0] DONE_OPEN     = 2'd0;
   localparam logic [1:0] DONE_FINISHED = 2'd1;
   localparam logic [1:0] DONE_NEG      = 2'd3;

   class heap_tracker;
      imhdk_pkg::cell_type order [imhdk_pkg::GRID_CELLS];
      imhdk_pkg::key_type  cell_key [imhdk_pkg::GRID_CELLS];
      imhdk_pkg::slot_type cell_slot [imhdk_pkg::GRID_CELLS];
      logic [1:0]          done_mark [imhdk_pkg::GRID_CELLS];
      int unsigned         fill;
      imhdk_pkg::res_type  heap_replies [$];
      int                  errors;

      function new();
         foreach (order[i]) begin
            order[i] = '0;
            cell_key[i] = '0;
            cell_slot[i] = '0;
            done_mark[i] = DONE_OPEN;
         end
         fill = 0;
         errors = 0;
      endfunction

      function int pending();
         return heap_replies.size();
      endfunction

      function void climb(imhdk_pkg::cell_type target, int unsigned pos);
         int unsigned up;
         while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!(cell_key[order[pos]] < cell_key[order[up]])) break;
            order[pos] = order[up];
            cell_slot[order[up]] = imhdk_pkg::slot_type'(pos);
            order[up] = target;
            cell_slot[target] = imhdk_pkg::slot_type'(up);
            pos = up;
         end
      endfunction

      function imhdk_pkg::cell_type remove_min();
         int unsigned n, pos, lc, rc;
         imhdk_pkg::cell_type top, mover;
         imhdk_pkg::key_type cur, lv, rv;
         n = fill - 1;
         top = order[0];
         mover = order[n];
         pos = 0;
         fill = n;
         done_mark[top] = DONE_FINISHED;
         order[0] = mover;
         cell_slot[mover] = '0;
         while (pos + 1 < n) begin
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            cur = cell_key[order[pos]];
            if (lc >= n) break;
            lv = cell_key[order[lc]];
            // tie between children keeps the left one
            if (rc < n) begin
               rv = cell_key[order[rc]];
               if (rv < lv) begin
                  lc = rc;
                  lv = rv;
               end
            end
            if (!(lv < cur)) break;
            order[pos] = order[lc];
            cell_slot[order[pos]] = imhdk_pkg::slot_type'(pos);
            order[lc] = order[n];
            cell_slot[order[n]] = imhdk_pkg::slot_type'(lc);
            pos = lc;
         end
         return top;
      endfunction

      function void note_command(logic [1:0] cmd, imhdk_pkg::cell_type target,
                                 imhdk_pkg::key_type key);
         imhdk_pkg::res_type r;
         int unsigned at;
         r = '0;
         case (cmd)
            imhdk_pkg::CMD_SET: begin
               cell_key[target] = key;
               cell_slot[target] = imhdk_pkg::SLOT_NONE;
               done_mark[target] = (key < 0) ? DONE_NEG : DONE_OPEN;
            end
            imhdk_pkg::CMD_ADD: begin
               at = 32'(cell_slot[target]);
               cell_key[target] = key;
               if (at >= imhdk_pkg::GRID_CELLS) begin
                  // full heap only takes the key
                  if (fill < imhdk_pkg::GRID_CELLS) begin
                     order[fill] = target;
                     cell_slot[target] = imhdk_pkg::slot_type'(fill);
                     climb(target, fill);
                     fill++;
                  end
               end else begin
                  climb(target, at);
               end
            end
            imhdk_pkg::CMD_POP: begin
               if (fill == 0) begin
                  r.heap_empty = 1'b1;
               end else begin
                  r.popped_cell = remove_min();
                  r.popped_key = cell_key[r.popped_cell];
               end
            end
            default: begin
            end
         endcase
         r.heap_count = imhdk_pkg::slot_type'(fill);
         heap_replies = {heap_replies, r};
      endfunction

      function void check_reply(logic [63:0] data, logic [0:0] user);
         imhdk_pkg::res_type want;
         imhdk_pkg::cell_type got_cell;
         imhdk_pkg::key_type got_key;
         imhdk_pkg::slot_type got_count;
         got_cell = data[11:0];
         got_key = data[43:12];
         got_count = data[56:44];
         if (heap_replies.size() == 0) begin
            $error("result transfer with no command waiting: cell %0d key %0d count %0d",
                   got_cell, got_key, got_count);
            errors++;
            return;
         end
         want = heap_replies.pop_front();
         if (got_cell !== want.popped_cell) begin
            $error("popped_cell expected %0d got %0d", want.popped_cell, got_cell);
            errors++;
         end
         if (got_key !== want.popped_key) begin
            $error("popped_key expected %0d got %0d", want.popped_key, got_key);
            errors++;
         end
         if (user[0] !== want.heap_empty) begin
            $error("heap_empty expected %0d got %0d", want.heap_empty, user[0]);
            errors++;
         end
         if (got_count !== want.heap_count) begin
            $error("heap_count expected %0d got %0d", want.heap_count, got_count);
            errors++;
         end
      endfunction
   endclass
endpackage

module tb_top;

   localparam int                 RANDOM_COMMANDS = 1350;
   localparam int                 CELL_POOL       = 48;
   localparam int                 FILL_CELLS      = 64;
   localparam int                 HOLD_AT         = 500;
   localparam int                 HOLD_CYCLES     = 400;
   localparam int                 STALL_LIMIT     = 5000;
   localparam int                 DRAIN_CYCLES    = 40;
   localparam imhdk_pkg::key_type KEY_MAX         = 32'sh7FFF_FFFF;
   localparam imhdk_pkg::key_type KEY_MIN         = 32'sh8000_0000;
   localparam imhdk_pkg::key_type FLAT_KEY        = 32'sh0001_8000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // cell_index[11:0], key_value[43:12]
   logic [1:0]  req_tuser = '0;    // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // popped_cell[11:0], popped_key[43:12], heap_count[56:44]
   logic [0:0]  rsp_tuser;         // heap_empty[0]

   tb_heap_pkg::heap_tracker tracker = new();
   bit          set_seen [imhdk_pkg::GRID_CELLS];
   int          sent_count = 0;
   int          reply_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   indexed_min_heap_decrease_key uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic imhdk_pkg::key_type pick_key();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) return imhdk_pkg::key_type'($urandom);
      if (r < 8) return imhdk_pkg::key_type'($urandom_range(0, 127)) - 64;
      if (r == 8) return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
      return $urandom_range(0, 1) ? imhdk_pkg::key_type'(0) : imhdk_pkg::key_type'(-1);
   endfunction

   function automatic imhdk_pkg::cell_type pick_cell();
      if ($urandom_range(0, 99) < 80) begin
         return imhdk_pkg::cell_type'($urandom_range(0, CELL_POOL - 1));
      end
      return imhdk_pkg::cell_type'($urandom_range(0, imhdk_pkg::GRID_CELLS - 1));
   endfunction

   task automatic send_command(input logic [1:0] cmd, input imhdk_pkg::cell_type target,
                               input imhdk_pkg::key_type key);
      int gap;
      gap = ((sent_count / 128) % 4 == 2) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'b0, key, target};
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.note_command(cmd, target, key);
      if (cmd == imhdk_pkg::CMD_SET) set_seen[target] = 1'b1;
      sent_count++;
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic drain_heap();
      while (tracker.fill != 0) send_command(imhdk_pkg::CMD_POP, pick_cell(), pick_key());
   endtask

   initial begin : stimulus
      logic [1:0] cmd;
      imhdk_pkg::cell_type target;
      int pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(imhdk_pkg::CMD_POP, 12'h000, 32'sh0);
      send_command(tb_heap_pkg::CMD_RESERVED, 12'hFFF, KEY_MAX);
      send_command(imhdk_pkg::CMD_SET, 12'h000, KEY_MAX);
      send_command(imhdk_pkg::CMD_SET, 12'hFFF, KEY_MIN);
      send_command(imhdk_pkg::CMD_SET, 12'h555, -1);
      send_command(imhdk_pkg::CMD_SET, 12'hAAA, 1);
      send_command(imhdk_pkg::CMD_SET, 12'h123, 0);
      send_command(imhdk_pkg::CMD_ADD, 12'h000, KEY_MAX);
      send_command(imhdk_pkg::CMD_ADD, 12'h555, -1);
      send_command(imhdk_pkg::CMD_ADD, 12'hAAA, 1);
      send_command(imhdk_pkg::CMD_ADD, 12'hFFF, KEY_MIN);
      send_command(imhdk_pkg::CMD_ADD, 12'h123, 0);
      // in-heap decrease that ties with the root
      send_command(imhdk_pkg::CMD_ADD, 12'h000, KEY_MIN);
      // re-set while in heap, then appended a second time
      send_command(imhdk_pkg::CMD_SET, 12'hAAA, 1);
      send_command(imhdk_pkg::CMD_ADD, 12'hAAA, -5);
      send_command(tb_heap_pkg::CMD_RESERVED, 12'h555, 32'sh1234_5678);
      send_command(imhdk_pkg::CMD_POP, 12'h000, 32'sh0);
      // popped cell only takes the new key
      send_command(imhdk_pkg::CMD_ADD, 12'hFFF, KEY_MAX);
      drain_heap();
      send_command(imhdk_pkg::CMD_POP, 12'hFFF, KEY_MIN);
      wait_for_replies();

      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         pick = $urandom_range(0, 99);
         target = pick_cell();
         if (pick < 28) cmd = imhdk_pkg::CMD_SET;
         else if (pick < 70) cmd = imhdk_pkg::CMD_ADD;
         else if (pick < 95) cmd = imhdk_pkg::CMD_POP;
         else cmd = tb_heap_pkg::CMD_RESERVED;
         if (cmd == imhdk_pkg::CMD_ADD && !set_seen[target]) cmd = imhdk_pkg::CMD_SET;
         send_command(cmd, target, pick_key());
      end
      wait_for_replies();

      // fill a run of cells with one key so sift-down sees only ties, then empty it
      drain_heap();
      for (int c = 0; c < FILL_CELLS; c++) begin
         send_command(imhdk_pkg::CMD_SET, imhdk_pkg::cell_type'(c), FLAT_KEY);
         send_command(imhdk_pkg::CMD_ADD, imhdk_pkg::cell_type'(c), FLAT_KEY);
      end
      send_command(imhdk_pkg::CMD_SET, 12'h007, FLAT_KEY);
      send_command(imhdk_pkg::CMD_ADD, 12'h007, FLAT_KEY);
      send_command(imhdk_pkg::CMD_ADD, 12'h010, FLAT_KEY);
      drain_heap();
      send_command(imhdk_pkg::CMD_POP, pick_cell(), pick_key());
      req_tvalid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (reply_count == HOLD_AT) stall = HOLD_CYCLES;
         else if ((reply_count / 128) % 4 == 3) stall = 0;
         else stall = $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         tracker.check_reply(rsp_tdata, rsp_tuser);
         reply_count++;
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

endmodule
